// File: sv/qtsfd_pkg.sv
// Package for the quadtree split-flag decoder.
// Holds the sequencer state type and the configuration register indexes.
// No dependencies.
package qtsfd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROOT_LOG2 = 2'd0;
  localparam logic [1:0] CFG_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_HEIGHT    = 2'd2;

  // Widths fixed by the field definitions.
  localparam int unsigned ROOT_W = 4;
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned SEG_XY_W   = 12;
  localparam int unsigned SEG_SIZE_W = 13;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADV,
    ST_EMIT
  } qt_state_t;

endpackage

// File: sv/qtsfd_if.sv
// Handshake interfaces for the quadtree split-flag decoder.
// Input channel carries split decisions, output channel carries leaf segments.
// Depends on qtsfd_pkg.
interface qtsfd_bit_if;
  logic valid;
  logic ready;
  logic split_bit;
  logic no_more_bits;

  modport source (output valid, output split_bit, output no_more_bits, input ready);
  modport sink   (input valid, input split_bit, input no_more_bits, output ready);
endinterface

interface qtsfd_seg_if
  import qtsfd_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [SEG_XY_W-1:0]   seg_x;
  logic [SEG_XY_W-1:0]   seg_y;
  logic [SEG_SIZE_W-1:0] seg_size;
  logic                  tree_done;

  modport source (output valid, output seg_x, output seg_y, output seg_size,
                  output tree_done, input ready);
  modport sink   (input valid, input seg_x, input seg_y, input seg_size,
                  input tree_done, output ready);
endinterface

// File: sv/quadtree_split_flag_decoder.sv
// Quadtree split-flag decoder: top level, sequencer and quadrant stack memory.
// Depends on qtsfd_pkg and the interfaces in qtsfd_if.sv.
//
//   channel  direction  beat contents
//   bits     in         split_bit, no_more_bits
//   segs     out        seg_x, seg_y, seg_size, tree_done
//   cfg      in         cfg_we, cfg_index, cfg_data (write only)
//
// A split decision is handled in ST_IDLE. A leaf goes from ST_IDLE through
// k >= 1 walk steps in ST_ADV (one per sibling stepped to or level popped,
// each a read-modify-write of the quadrant stack memory) to ST_EMIT, which
// loads the output register. A leaf at the root goes from ST_IDLE to ST_EMIT.
// Reset is synchronous; the stack memory needs no clearing, as every level is
// written when it is entered. A stalled output holds the walk in its last state.
module quadtree_split_flag_decoder
  import qtsfd_pkg::*;
#(
  parameter int unsigned MAX_LOG_SIZE = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  qtsfd_bit_if.sink             bits,
  qtsfd_seg_if.source           segs,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [DIM_W-1:0]      cfg_data
);

  localparam int unsigned LW   = (MAX_LOG_SIZE < 2) ? 1 : $clog2(MAX_LOG_SIZE + 1);
  localparam int unsigned CW   = MAX_LOG_SIZE;
  localparam int unsigned SW   = MAX_LOG_SIZE + 1;
  localparam int unsigned CMPW = (CW > DIM_W) ? CW : DIM_W;
  localparam logic [ROOT_W-1:0] MAX_R = ROOT_W'(MAX_LOG_SIZE);
  localparam logic [LW-1:0]     MAX_L = LW'(MAX_LOG_SIZE);

  // Configuration registers.
  logic [ROOT_W-1:0] root_size_log2;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;

  // Walk state.
  qt_state_t        state, state_next;
  logic [LW-1:0]    level, level_next;
  logic [CW-1:0]    cur_x, cur_x_next;
  logic [CW-1:0]    cur_y, cur_y_next;
  logic             use_fwd, use_fwd_next;
  logic [1:0]       q_fwd, q_fwd_next;
  logic [CW-1:0]    leaf_x, leaf_x_next;
  logic [CW-1:0]    leaf_y, leaf_y_next;
  logic [SW-1:0]    leaf_size, leaf_size_next;
  logic             leaf_done, leaf_done_next;

  // Output register.
  logic                  o_vld;
  logic [SEG_XY_W-1:0]   o_x;
  logic [SEG_XY_W-1:0]   o_y;
  logic [SEG_SIZE_W-1:0] o_size;
  logic                  o_done;
  logic                  emit_load;

  // Quadrant stack memory.
  logic [1:0]    quad_mem [0:MAX_LOG_SIZE];
  logic          mem_we;
  logic [LW-1:0] mem_wa;
  logic [1:0]    mem_wd;
  logic [LW-1:0] mem_ra;
  logic [1:0]    mem_rd;

  // Datapath terms.
  logic [ROOT_W-1:0] root_eff;
  logic [ROOT_W-1:0] lvl4;
  logic [ROOT_W-1:0] shamt;
  logic [SW-1:0]     size;
  logic [CW-1:0]     s_cw;
  logic              decision;
  logic              can_split;
  logic [1:0]        q, qn;
  logic [CW-1:0]     px, py, nx, ny;
  logic              in_bounds;
  logic [CMPW-1:0]   x_ext, y_ext;
  logic [CMPW:0]     size_ext;

  // Block side at the current level.
  always_comb begin
    root_eff = (root_size_log2 > MAX_R) ? MAX_R : root_size_log2;
    lvl4     = ROOT_W'(level);
    shamt    = root_eff - lvl4;
    size     = (lvl4 <= root_eff) ? (SW'(1) << shamt) : SW'(1);
    s_cw     = size[CW-1:0];
    decision = bits.split_bit && !bits.no_more_bits;
    can_split = decision && (level < MAX_L) &&
                (({1'b0, lvl4} + 5'd2) <= {1'b0, root_eff});
  end

  // Parent origin and next sibling of the current quadrant.
  always_comb begin
    q  = use_fwd ? q_fwd : mem_rd;
    qn = q + 2'd1;
    px = cur_x - (q[0] ? s_cw : '0);
    py = cur_y - (q[1] ? s_cw : '0);
    nx = px + (qn[0] ? s_cw : '0);
    ny = py + (qn[1] ? s_cw : '0);
    in_bounds = (CMPW'(nx) < CMPW'(image_width)) && (CMPW'(ny) < CMPW'(image_height));
  end

  assign emit_load  = (state == ST_EMIT) && (!o_vld || segs.ready);
  assign bits.ready = (state == ST_IDLE);

  // Sequencer: next state, stack accesses and walk updates.
  always_comb begin
    state_next     = state;
    level_next     = level;
    cur_x_next     = cur_x;
    cur_y_next     = cur_y;
    use_fwd_next   = use_fwd;
    q_fwd_next     = q_fwd;
    leaf_x_next    = leaf_x;
    leaf_y_next    = leaf_y;
    leaf_size_next = leaf_size;
    leaf_done_next = leaf_done;
    mem_we = 1'b0;
    mem_wa = level;
    mem_wd = 2'd0;
    mem_ra = level;
    case (state)
      ST_IDLE: begin
        if (bits.valid) begin
          if (can_split) begin
            // Descend into the top-left quadrant.
            level_next = level + LW'(1);
            mem_we = 1'b1;
            mem_wa = level + LW'(1);
            mem_wd = 2'd0;
          end else begin
            leaf_x_next    = cur_x;
            leaf_y_next    = cur_y;
            leaf_size_next = size;
            if (level == '0) begin
              // A leaf at the root ends the tree at once.
              leaf_done_next = 1'b1;
              state_next     = ST_EMIT;
            end else begin
              use_fwd_next = 1'b0;
              state_next   = ST_ADV;
            end
          end
        end
      end
      ST_ADV: begin
        mem_we = 1'b1;
        mem_wa = level;
        if (q != 2'd3) begin
          // Step to the next sibling; skip it if it starts outside the image.
          mem_wd     = qn;
          cur_x_next = nx;
          cur_y_next = ny;
          if (in_bounds) begin
            leaf_done_next = 1'b0;
            state_next     = ST_EMIT;
          end else begin
            use_fwd_next = 1'b1;
            q_fwd_next   = qn;
          end
        end else begin
          // Last quadrant done: pop one level.
          mem_wd = 2'd0;
          if (level == LW'(1)) begin
            level_next     = '0;
            cur_x_next     = '0;
            cur_y_next     = '0;
            leaf_done_next = 1'b1;
            state_next     = ST_EMIT;
          end else begin
            level_next   = level - LW'(1);
            cur_x_next   = px;
            cur_y_next   = py;
            mem_ra       = level - LW'(1);
            use_fwd_next = 1'b0;
          end
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // A new root size restarts the walk.
    if (cfg_we && (cfg_index == CFG_ROOT_LOG2)) begin
      level_next = '0;
      cur_x_next = '0;
      cur_y_next = '0;
    end
  end

  // Control and walk registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      level   <= '0;
      cur_x   <= '0;
      cur_y   <= '0;
      use_fwd <= 1'b0;
    end else begin
      state   <= state_next;
      level   <= level_next;
      cur_x   <= cur_x_next;
      cur_y   <= cur_y_next;
      use_fwd <= use_fwd_next;
    end
  end

  // Payload registers of the walk.
  always_ff @(posedge clk) begin
    q_fwd     <= q_fwd_next;
    leaf_x    <= leaf_x_next;
    leaf_y    <= leaf_y_next;
    leaf_size <= leaf_size_next;
    leaf_done <= leaf_done_next;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_size_log2 <= ROOT_W'(9);
      image_width    <= DIM_W'(512);
      image_height   <= DIM_W'(512);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROOT_LOG2: root_size_log2 <= cfg_data[ROOT_W-1:0];
        CFG_WIDTH:     image_width    <= cfg_data;
        CFG_HEIGHT:    image_height   <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Quadrant stack memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      quad_mem[mem_wa] <= mem_wd;
    end
    mem_rd <= quad_mem[mem_ra];
  end

  // Output register; a waiting beat only holds up the next leaf in ST_EMIT.
  always_comb begin
    x_ext    = CMPW'(leaf_x);
    y_ext    = CMPW'(leaf_y);
    size_ext = (CMPW + 1)'(leaf_size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (emit_load) begin
      o_vld <= 1'b1;
    end else if (segs.ready) begin
      o_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      o_x    <= x_ext[SEG_XY_W-1:0];
      o_y    <= y_ext[SEG_XY_W-1:0];
      o_size <= size_ext[SEG_SIZE_W-1:0];
      o_done <= leaf_done;
    end
  end

  assign segs.valid     = o_vld;
  assign segs.seg_x     = o_x;
  assign segs.seg_y     = o_y;
  assign segs.seg_size  = o_size;
  assign segs.tree_done = o_done;

  // The walk never runs at the root.
  a_adv_not_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADV) |-> (level != '0))
    else $error("walk step taken at root level");

  // The depth stays within the stack.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= MAX_L)
    else $error("level beyond stack depth");

  // An output beat only appears after the emit state.
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(o_vld) |-> ($past(state) == ST_EMIT))
    else $error("output beat raised outside emit");

  // A forwarded quadrant index always follows an increment.
  a_fwd_nonzero: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_ADV) && use_fwd) |-> (q_fwd != 2'd0))
    else $error("forwarded quadrant index is zero");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the quadtree split-flag decoder.
// Drives split-decision beats and register writes, predicts each leaf segment with
// its own model of the preorder walk and checks every segment beat. Needs qtsfd_pkg and qtsfd_if.sv.
module testbench;
  import qtsfd_pkg::*;

  localparam int unsigned MAX_LOG       = 12;
  localparam int unsigned SPLIT_LIMIT   = 2;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned RANDOM_ITEMS  = 2000;
  localparam int unsigned PRINT_CAP     = 100;

  typedef struct packed {
    logic [SEG_XY_W-1:0]   x;
    logic [SEG_XY_W-1:0]   y;
    logic [SEG_SIZE_W-1:0] size;
    logic                  done;
  } seg_t;

  typedef enum logic {ROW_BIT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [1:0]       idx;
    logic [DIM_W-1:0] data;
    logic             sb;
    logic             nmb;
    bit               typed;
    seg_t             seg;
  } row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = CFG_ROOT_LOG2;
  logic [DIM_W-1:0] cfg_data = '0;

  qtsfd_bit_if bits_if ();
  qtsfd_seg_if segs_if ();

  quadtree_split_flag_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .bits      (bits_if),
    .segs      (segs_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: configuration and the walk position.
  logic [ROOT_W-1:0] cfg_root;
  logic [DIM_W-1:0]  cfg_w;
  logic [DIM_W-1:0]  cfg_h;
  logic [1:0]        quad_stack [0:MAX_LOG];
  int unsigned       lvl;
  int unsigned       cur_x;
  int unsigned       cur_y;

  seg_t seg_expect [$];
  row_t dir_rows [$];
  int   mismatches  = 0;
  int   idle_cycles = 0;
  int   sink_hold   = 0;
  bit   calm        = 1'b0;

  // Prediction of the walk.
  function automatic int unsigned eff_root();
    return (cfg_root > MAX_LOG) ? MAX_LOG : cfg_root;
  endfunction

  function automatic int unsigned side_of(input int unsigned l);
    int unsigned r;
    r = eff_root();
    return (l <= r) ? (32'd1 << (r - l)) : 32'd1;
  endfunction

  function automatic void restart_walk();
    for (int i = 0; i <= MAX_LOG; i++) quad_stack[i] = 2'd0;
    lvl   = 0;
    cur_x = 0;
    cur_y = 0;
  endfunction

  // Moves to the next block inside the image in preorder; returns 1 when the tree ends.
  function automatic bit walk_next();
    int unsigned s;
    int unsigned px;
    int unsigned py;
    logic [1:0]  q;
    while (1) begin
      if (lvl == 0 || lvl > MAX_LOG) begin
        restart_walk();
        return 1'b1;
      end
      s  = side_of(lvl);
      q  = quad_stack[lvl];
      px = cur_x - (q[0] ? s : 0);
      py = cur_y - (q[1] ? s : 0);
      if (q != 2'd3) begin
        q = q + 2'd1;
        quad_stack[lvl] = q;
        cur_x = px + (q[0] ? s : 0);
        cur_y = py + (q[1] ? s : 0);
        if (cur_x < cfg_w && cur_y < cfg_h) return 1'b0;
      end else begin
        quad_stack[lvl] = 2'd0;
        lvl   = lvl - 1;
        cur_x = px;
        cur_y = py;
      end
    end
    return 1'b1;
  endfunction

  function automatic void walk_step(input logic sb, input logic nmb,
                                    output bit has, output seg_t r);
    int unsigned sz;
    sz  = side_of(lvl);
    has = 1'b0;
    r   = '0;
    if (sb && !nmb && sz > SPLIT_LIMIT && lvl < MAX_LOG) begin
      lvl = lvl + 1;
      quad_stack[lvl] = 2'd0;
      return;
    end
    r.x    = cur_x[SEG_XY_W-1:0];
    r.y    = cur_y[SEG_XY_W-1:0];
    r.size = sz[SEG_SIZE_W-1:0];
    r.done = walk_next();
    has    = 1'b1;
  endfunction

  function automatic void note_cfg(input logic [1:0] idx, input logic [DIM_W-1:0] data);
    case (idx)
      CFG_ROOT_LOG2: begin
        cfg_root = data[ROOT_W-1:0];
        restart_walk();
      end
      CFG_WIDTH:  cfg_w = data;
      CFG_HEIGHT: cfg_h = data;
      default: ;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one; none at all in a calm phase.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Directed table builders.
  function automatic void add_cfg(input logic [1:0] idx, input logic [DIM_W-1:0] data);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, sb: 1'b0, nmb: 1'b0, typed: 1'b0, seg: '0};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_bit(input logic sb, input logic nmb);
    row_t r;
    r = '{kind: ROW_BIT, idx: CFG_ROOT_LOG2, data: '0, sb: sb, nmb: nmb, typed: 1'b0,
          seg: '0};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_leaf(input logic sb, input logic nmb, input int unsigned x,
                                   input int unsigned y, input int unsigned size,
                                   input logic done);
    row_t r;
    r = '{kind: ROW_BIT, idx: CFG_ROOT_LOG2, data: '0, sb: sb, nmb: nmb, typed: 1'b1,
          seg: '{x: x[SEG_XY_W-1:0], y: y[SEG_XY_W-1:0], size: size[SEG_SIZE_W-1:0],
                 done: done}};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // One decision beat, with a random gap in front of it.
  task automatic send_bit(input logic sb, input logic nmb, input bit typed, input seg_t tseg);
    int   pause;
    bit   has;
    seg_t res;
    pause = pick_gap();
    if (pause > 0) begin
      bits_if.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    bits_if.valid        <= 1'b1;
    bits_if.split_bit    <= sb;
    bits_if.no_more_bits <= nmb;
    do @(posedge clk); while (!bits_if.ready);
    walk_step(sb, nmb, has, res);
    if (typed) begin
      has = 1'b1;
      res = tseg;
    end
    if (has) seg_expect.insert(seg_expect.size(), res);
  endtask

  // Lets the block drain before any register write.
  task automatic settle();
    bits_if.valid <= 1'b0;
    while (seg_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_cfg(input logic [1:0] idx, input logic [DIM_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    note_cfg(idx, data);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim(input int unsigned side);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return DIM_W'(4096);
    if (r < 14) return DIM_W'($urandom_range(4097, 8191));
    return DIM_W'($urandom_range(1, side + side / 2 + 1));
  endfunction

  // Output side: ready with random stalls.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      segs_if.ready <= 1'b0;
      sink_hold     <= sink_hold - 1;
    end else begin
      segs_if.ready <= 1'b1;
      sink_hold     <= pick_gap();
    end
  end

  // Segment checker against the oldest expectation.
  always @(posedge clk) begin : seg_check
    seg_t e;
    if (!rst && segs_if.valid && segs_if.ready) begin
      if (seg_expect.size() == 0) begin
        report_mismatch($sformatf("segment beat (%0d,%0d,%0d,%0b) with nothing expected",
                                  segs_if.seg_x, segs_if.seg_y, segs_if.seg_size,
                                  segs_if.tree_done));
      end else begin
        e = seg_expect.pop_front();
        if (segs_if.seg_x !== e.x)
          report_mismatch($sformatf("seg_x %0d, expected %0d", segs_if.seg_x, e.x));
        if (segs_if.seg_y !== e.y)
          report_mismatch($sformatf("seg_y %0d, expected %0d", segs_if.seg_y, e.y));
        if (segs_if.seg_size !== e.size)
          report_mismatch($sformatf("seg_size %0d, expected %0d", segs_if.seg_size, e.size));
        if (segs_if.tree_done !== e.done)
          report_mismatch($sformatf("tree_done %0b, expected %0b", segs_if.tree_done, e.done));
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if ((bits_if.valid && bits_if.ready) || (segs_if.valid && segs_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin : main_seq
    int          sent;
    int          n;
    int          p_split;
    int          mask;
    int          r;
    int unsigned root;
    bit          first;
    bit          prev_bit;
    logic        sb;
    logic        nmb;

    bits_if.valid        <= 1'b0;
    bits_if.split_bit    <= 1'b0;
    bits_if.no_more_bits <= 1'b0;
    cfg_root = 4'd9;
    cfg_w    = DIM_W'(512);
    cfg_h    = DIM_W'(512);
    restart_walk();

    // Leaf at the root after reset, also from an exhausted stream.
    add_leaf(1'b0, 1'b0, 0, 0, 512, 1'b1);
    add_leaf(1'b1, 1'b1, 0, 0, 512, 1'b1);
    add_bit(1'b1, 1'b0);
    add_bit(1'b0, 1'b0);
    // Blocks of side 2 and 1 are leaves whatever the bit.
    add_cfg(CFG_ROOT_LOG2, DIM_W'(1));
    add_leaf(1'b1, 1'b0, 0, 0, 2, 1'b1);
    add_cfg(CFG_ROOT_LOG2, DIM_W'(0));
    add_leaf(1'b1, 1'b0, 0, 0, 1, 1'b1);
    // An oversized root is clamped to the largest size.
    add_cfg(CFG_WIDTH, DIM_W'(4096));
    add_cfg(CFG_HEIGHT, DIM_W'(4096));
    add_cfg(CFG_ROOT_LOG2, DIM_W'(15));
    add_leaf(1'b0, 1'b0, 0, 0, 4096, 1'b1);
    // Quadrants outside a narrow image are skipped.
    add_cfg(CFG_ROOT_LOG2, DIM_W'(2));
    add_cfg(CFG_WIDTH, DIM_W'(3));
    add_cfg(CFG_HEIGHT, DIM_W'(1));
    add_bit(1'b1, 1'b0);
    add_bit(1'b0, 1'b0);
    add_bit(1'b1, 1'b0);
    // An empty image still decodes its root.
    add_cfg(CFG_WIDTH, DIM_W'(0));
    add_leaf(1'b0, 1'b0, 0, 0, 4, 1'b1);
    add_bit(1'b1, 1'b0);
    add_bit(1'b0, 1'b1);
    // Deepest walk, then the image shrinks under a tree in progress.
    add_cfg(CFG_ROOT_LOG2, DIM_W'(12));
    add_cfg(CFG_WIDTH, DIM_W'(4096));
    add_cfg(CFG_HEIGHT, DIM_W'(4096));
    for (int i = 0; i < 11; i++) add_bit(1'b1, 1'b0);
    add_bit(1'b0, 1'b0);
    add_cfg(CFG_WIDTH, DIM_W'(1));
    add_cfg(CFG_HEIGHT, DIM_W'(1));
    add_bit(1'b1, 1'b1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    prev_bit = 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (prev_bit) settle();
        apply_cfg(dir_rows[i].idx, dir_rows[i].data);
        prev_bit = 1'b0;
      end else begin
        cfg_we <= 1'b0;
        send_bit(dir_rows[i].sb, dir_rows[i].nmb, dir_rows[i].typed, dir_rows[i].seg);
        prev_bit = 1'b1;
      end
    end

    // Random phases, each with its own settings and split density.
    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 70)      root = $urandom_range(1, 6);
      else if (r < 78) root = 0;
      else if (r < 90) root = $urandom_range(7, 12);
      else if (r < 95) root = 12;
      else             root = $urandom_range(13, 15);
      mask = first ? 7 : $urandom_range(0, 7);
      first = 1'b0;
      if (mask[0]) apply_cfg(CFG_ROOT_LOG2, DIM_W'(root));
      if (mask[1]) apply_cfg(CFG_WIDTH, pick_dim(side_of(0)));
      if (mask[2]) apply_cfg(CFG_HEIGHT, pick_dim(side_of(0)));
      cfg_we <= 1'b0;
      calm    = ($urandom_range(0, 3) == 0);
      p_split = $urandom_range(15, 60);
      n       = $urandom_range(100, 300);
      for (int k = 0; k < n; k++) begin
        nmb = ($urandom_range(0, 99) < 5);
        sb  = ($urandom_range(0, 99) < p_split);
        send_bit(sb, nmb, 1'b0, '0);
        sent++;
      end
    end

    bits_if.valid <= 1'b0;
    while (seg_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
